// ===== rtl/core/isotp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the ISO-TP reassembler.
// No dependencies; every module of the block imports this package.
package isotp_pkg;

   localparam int unsigned FRAME_BYTES = 8;
   localparam int unsigned CHUNK_BYTES = 7;
   localparam int unsigned LEN_W = 12;

   localparam logic [LEN_W-1:0] MAX_MESSAGE_BYTES = 12'd4095;
   localparam logic [LEN_W-1:0] CAPACITY_RESET = 12'd4095;

   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST = 4'h1;
   localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_PROGRESS = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_BADLEN = 3'd2,
      ST_SHORT = 3'd3,
      ST_BADTYPE = 3'd4,
      ST_BADSEQ = 3'd5,
      ST_INCOMPLETE = 3'd6,
      ST_IGNORED = 3'd7
   } status_type;

   typedef struct packed {
      logic [8*FRAME_BYTES-1:0] data;
      logic [3:0] len;
      logic last;
   } frame_type;

   typedef struct packed {
      phase_type phase;
      logic [LEN_W-1:0] total_length;
      logic [LEN_W-1:0] byte_offset;
      logic [3:0] expected_sequence;
   } rx_state_type;

   typedef struct packed {
      logic [8*CHUNK_BYTES-1:0] chunk_data;
      logic [2:0] chunk_len;
      logic [LEN_W-1:0] chunk_offset;
      logic [LEN_W-1:0] message_length;
      status_type status;
   } result_type;

endpackage

// ===== rtl/core/isotp_req_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one received CAN frame per transaction.
// Depends on nothing.
interface isotp_req_if;
   logic valid;
   logic ready;
   logic [63:0] frame_data;
   logic [3:0] frame_len;
   logic last_frame;

   modport source (output valid, output frame_data, output frame_len, output last_frame,
                   input ready);
   modport sink (input valid, input frame_data, input frame_len, input last_frame,
                 output ready);
endinterface

// ===== rtl/core/isotp_rsp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one reassembly result per transaction.
// Depends on nothing.
interface isotp_rsp_if;
   logic valid;
   logic ready;
   logic [55:0] chunk_data;
   logic [2:0] chunk_len;
   logic [11:0] chunk_offset;
   logic [11:0] message_length;
   logic [2:0] status;

   modport source (output valid, output chunk_data, output chunk_len, output chunk_offset,
                   output message_length, output status, input ready);
   modport sink (input valid, input chunk_data, input chunk_len, input chunk_offset,
                 input message_length, input status, output ready);
endinterface

// ===== rtl/core/isotp_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the reassembler: captures one frame transaction.
// Depends on isotp_pkg and isotp_req_if.
module isotp_in_stage
   import isotp_pkg::*;
(
   input logic clock,
   input logic reset,
   isotp_req_if.sink req_chan,
   input logic advance,
   output logic frame_valid,
   output frame_type frame
);

   logic valid_ff;
   logic valid_in;
   frame_type frame_ff;
   logic load;

   assign req_chan.ready = !valid_ff || advance;
   assign load = req_chan.valid && req_chan.ready;
   assign valid_in = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         frame_ff.data <= req_chan.frame_data;
         frame_ff.len <= req_chan.frame_len;
         frame_ff.last <= req_chan.last_frame;
      end
   end

   assign frame_valid = valid_ff;
   assign frame = frame_ff;

endmodule

// ===== rtl/core/isotp_decode.sv =====
`timescale 1ns / 1ps
// Frame decoder: checks one frame against the receive state and forms the
// result and the next state. Depends on isotp_pkg.
module isotp_decode
   import isotp_pkg::*;
(
   input frame_type frame,
   input rx_state_type state,
   input logic [LEN_W-1:0] capacity,
   output rx_state_type state_next,
   output result_type result
);

   function automatic logic [8*CHUNK_BYTES-1:0] byte_mask(input logic [2:0] n);
      logic [8*CHUNK_BYTES-1:0] m;
      m = '0;
      for (int k = 0; k < CHUNK_BYTES; k++) begin
         if (3'(k) < n) begin
            m[8*(CHUNK_BYTES-1-k) +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   logic [3:0] flen;
   logic [7:0] pci;
   logic [3:0] pci_type;
   logic [3:0] pci_low;
   logic [LEN_W-1:0] ff_len;
   logic [LEN_W-1:0] remaining;
   logic [2:0] cf_n;
   logic [LEN_W-1:0] new_offset;
   status_type status;

   assign flen = (frame.len > 4'd8) ? 4'd8 : frame.len;
   assign pci = frame.data[63:56];
   assign pci_type = pci[7:4];
   assign pci_low = pci[3:0];
   assign ff_len = {pci_low, frame.data[55:48]};
   assign remaining = (state.total_length > state.byte_offset) ?
                      state.total_length - state.byte_offset : '0;
   assign cf_n = (remaining > 12'd7) ? 3'd7 : remaining[2:0];
   assign new_offset = state.byte_offset + {9'd0, cf_n};

   always_comb begin
      state_next = state;
      result.chunk_data = '0;
      result.chunk_len = '0;
      result.chunk_offset = '0;
      status = ST_IGNORED;
      case (state.phase)
         PH_IDLE: begin
            state_next.total_length = '0;
            if (flen == 4'd0) begin
               status = ST_SHORT;
            end else if (pci_type == PCI_SINGLE) begin
               if (pci_low > 4'd7 || {8'd0, pci_low} > capacity) begin
                  status = ST_BADLEN;
               end else if ({1'b0, flen} < {1'b0, pci_low} + 5'd1) begin
                  status = ST_SHORT;
               end else begin
                  state_next.total_length = {8'd0, pci_low};
                  result.chunk_data = frame.data[55:0] & byte_mask(pci_low[2:0]);
                  result.chunk_len = pci_low[2:0];
                  status = ST_COMPLETE;
               end
            end else if (pci_type == PCI_FIRST) begin
               if (ff_len <= 12'd7 || ff_len > capacity || ff_len > MAX_MESSAGE_BYTES) begin
                  status = ST_BADLEN;
               end else if (flen < 4'd8) begin
                  status = ST_SHORT;
               end else begin
                  state_next.total_length = ff_len;
                  result.chunk_data = {frame.data[47:0], 8'd0};
                  result.chunk_len = 3'd6;
                  state_next.byte_offset = 12'd6;
                  state_next.expected_sequence = 4'd1;
                  status = ST_PROGRESS;
               end
            end else begin
               status = ST_BADTYPE;
            end
            state_next.phase = (status == ST_PROGRESS) ? PH_RECV : PH_DONE;
         end
         PH_RECV: begin
            if (flen == 4'd0) begin
               status = ST_SHORT;
            end else if (pci_type != PCI_CONSECUTIVE) begin
               status = ST_BADTYPE;
            end else if (pci_low != state.expected_sequence) begin
               status = ST_BADSEQ;
            end else if ({1'b0, flen} < {2'b0, cf_n} + 5'd1) begin
               status = ST_SHORT;
            end else begin
               result.chunk_data = frame.data[55:0] & byte_mask(cf_n);
               result.chunk_len = cf_n;
               result.chunk_offset = state.byte_offset;
               state_next.byte_offset = new_offset;
               state_next.expected_sequence = state.expected_sequence + 4'd1;
               status = (new_offset >= state.total_length) ? ST_COMPLETE : ST_PROGRESS;
            end
            if (status != ST_PROGRESS) begin
               state_next.phase = PH_DONE;
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase
      if (frame.last) begin
         if (status == ST_PROGRESS) begin
            status = ST_INCOMPLETE;
         end
         state_next.phase = PH_IDLE;
      end
      result.status = status;
      result.message_length = state_next.total_length;
   end

endmodule

// ===== rtl/core/isotp_reassembler_top.sv =====
`timescale 1ns / 1ps
// ISO-TP receive reassembler: one result transaction for every frame transaction, one
// frame per clock cycle sustained while results are taken. An accepted frame passes from the
// input register through combinational decode into the result register. A result that is
// not taken holds the frame in the input register and stalls further frames until the result
// is taken.
// Depends on isotp_pkg, isotp_req_if, isotp_rsp_if, isotp_in_stage, isotp_decode.
module isotp_reassembler_top
   import isotp_pkg::*;
(
   input logic clock,
   input logic reset,
   isotp_req_if.sink req_chan,
   isotp_rsp_if.source rsp_chan,
   input logic csr_wr_en,
   input logic [11:0] csr_wr_data
);

   logic frame_valid;
   frame_type frame;
   logic advance;
   logic out_valid_ff;
   logic out_valid_in;
   result_type out_ff;
   result_type result;
   rx_state_type state_ff;
   rx_state_type state_in;
   logic [LEN_W-1:0] capacity_ff;

   assign advance = frame_valid && (!out_valid_ff || rsp_chan.ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   isotp_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .advance(advance),
      .frame_valid(frame_valid),
      .frame(frame)
   );

   isotp_decode u_decode (
      .frame(frame),
      .state(state_ff),
      .capacity(capacity_ff),
      .state_next(state_in),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         state_ff.phase <= PH_IDLE;
         state_ff.total_length <= '0;
         state_ff.byte_offset <= '0;
         state_ff.expected_sequence <= 4'd1;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.chunk_data = out_ff.chunk_data;
   assign rsp_chan.chunk_len = out_ff.chunk_len;
   assign rsp_chan.chunk_offset = out_ff.chunk_offset;
   assign rsp_chan.message_length = out_ff.message_length;
   assign rsp_chan.status = 3'(out_ff.status);

endmodule

// ===== bench/isotp_reassembly_checker.sv =====
`timescale 1ns / 1ps
// Watches the frame and result channels of the ISO-TP reassembler, predicts each result and
// compares it field by field. Depends on isotp_pkg, isotp_req_if and isotp_rsp_if.
module isotp_reassembly_checker
   import isotp_pkg::*;
(
   input logic clock,
   input logic reset,
   isotp_req_if req_mon,
   isotp_rsp_if rsp_mon,
   input logic csr_wr_en,
   input logic [11:0] csr_wr_data,
   output int unsigned failures,
   output int unsigned outstanding
);

   rx_state_type rx;
   logic [LEN_W-1:0] capacity;
   result_type expected_results[$];
   int unsigned fail_count = 0;

   function automatic logic [55:0] slice_payload(logic [63:0] data, int unsigned first,
                                                 int unsigned count);
      logic [55:0] payload;
      payload = '0;
      for (int k = 0; k < 7; k++) begin
         if (k < count && first + k < 8) begin
            payload[55-8*k -: 8] = data[63-8*(first+k) -: 8];
         end
      end
      return payload;
   endfunction

   function automatic result_type reassemble_frame(frame_type f);
      result_type r;
      status_type st;
      logic [7:0] pci;
      int unsigned nbytes;
      int unsigned announced;
      int unsigned remaining;
      int unsigned take;
      r = '0;
      st = ST_IGNORED;
      pci = f.data[63:56];
      nbytes = (f.len > 4'd8) ? 8 : int'(f.len);
      case (rx.phase)
         PH_IDLE: begin
            rx.total_length = '0;
            if (nbytes == 0) begin
               st = ST_SHORT;
            end else if (pci[7:4] == PCI_SINGLE) begin
               announced = int'(pci[3:0]);
               if (announced > 7 || announced > int'(capacity)) begin
                  st = ST_BADLEN;
               end else if (nbytes < announced + 1) begin
                  st = ST_SHORT;
               end else begin
                  rx.total_length = LEN_W'(announced);
                  r.chunk_data = slice_payload(f.data, 1, announced);
                  r.chunk_len = 3'(announced);
                  st = ST_COMPLETE;
               end
            end else if (pci[7:4] == PCI_FIRST) begin
               announced = int'({pci[3:0], f.data[55:48]});
               if (announced <= 7 || announced > int'(capacity) ||
                   announced > int'(MAX_MESSAGE_BYTES)) begin
                  st = ST_BADLEN;
               end else if (nbytes < 8) begin
                  st = ST_SHORT;
               end else begin
                  rx.total_length = LEN_W'(announced);
                  r.chunk_data = slice_payload(f.data, 2, 6);
                  r.chunk_len = 3'd6;
                  rx.byte_offset = LEN_W'(6);
                  rx.expected_sequence = 4'd1;
                  st = ST_PROGRESS;
               end
            end else begin
               st = ST_BADTYPE;
            end
            rx.phase = (st == ST_PROGRESS) ? PH_RECV : PH_DONE;
         end
         PH_RECV: begin
            if (nbytes == 0) begin
               st = ST_SHORT;
            end else if (pci[7:4] != PCI_CONSECUTIVE) begin
               st = ST_BADTYPE;
            end else if (pci[3:0] != rx.expected_sequence) begin
               st = ST_BADSEQ;
            end else begin
               remaining = (rx.total_length > rx.byte_offset) ?
                           int'(rx.total_length - rx.byte_offset) : 0;
               take = (remaining > 7) ? 7 : remaining;
               if (nbytes < take + 1) begin
                  st = ST_SHORT;
               end else begin
                  r.chunk_data = slice_payload(f.data, 1, take);
                  r.chunk_len = 3'(take);
                  r.chunk_offset = rx.byte_offset;
                  rx.byte_offset = rx.byte_offset + LEN_W'(take);
                  rx.expected_sequence = rx.expected_sequence + 4'd1;
                  st = (rx.byte_offset >= rx.total_length) ? ST_COMPLETE : ST_PROGRESS;
               end
            end
            if (st != ST_PROGRESS) begin
               rx.phase = PH_DONE;
            end
         end
         default: begin
            st = ST_IGNORED;
         end
      endcase
      if (f.last) begin
         if (st == ST_PROGRESS) begin
            st = ST_INCOMPLETE;
         end
         rx.phase = PH_IDLE;
      end
      r.message_length = rx.total_length;
      r.status = st;
      return r;
   endfunction

   function automatic int unsigned field_differs(string name, logic [63:0] want,
                                                 logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      frame_type f;
      if (reset) begin
         rx.phase = PH_IDLE;
         rx.total_length = '0;
         rx.byte_offset = '0;
         rx.expected_sequence = 4'd1;
         capacity = CAPACITY_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            capacity = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("Result transaction with no frame outstanding: status 0x%0h",
                      rsp_mon.status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               fail_count += field_differs("chunk_data", 64'(want.chunk_data),
                                           64'(rsp_mon.chunk_data));
               fail_count += field_differs("chunk_len", 64'(want.chunk_len),
                                           64'(rsp_mon.chunk_len));
               fail_count += field_differs("chunk_offset", 64'(want.chunk_offset),
                                           64'(rsp_mon.chunk_offset));
               fail_count += field_differs("message_length", 64'(want.message_length),
                                           64'(rsp_mon.message_length));
               fail_count += field_differs("status", 64'(want.status),
                                           64'(rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            f.data = req_mon.frame_data;
            f.len = req_mon.frame_len;
            f.last = req_mon.last_frame;
            expected_results.push_back(reassemble_frame(f));
         end
      end
      failures <= fail_count;
      outstanding <= expected_results.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the ISO-TP reassembler testbench: clock, reset, frame and capacity stimulus, result
// back-pressure and the verdict. Depends on isotp_pkg, both channel interfaces,
// isotp_reassembler_top and isotp_reassembly_checker.
module tb;
   import isotp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_FRAMES = 500;
   localparam int unsigned PLAN_SIZE = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [11:0] csr_wr_data;
   int unsigned failures;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   int unsigned frames_sent = 0;
   int unsigned lists_sent = 0;
   int unsigned settings_used = 0;
   logic [LEN_W-1:0] capacity_now = CAPACITY_RESET;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   isotp_req_if req_chan();
   isotp_rsp_if rsp_chan();

   isotp_reassembler_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   isotp_reassembly_checker result_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .failures(failures),
      .outstanding(outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int unsigned idle_cycles(bit steady);
      return steady ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic logic [3:0] frame_len_for(int unsigned need);
      return 4'(($urandom_range(0, 3) == 0) ? $urandom_range(need, 15) : need);
   endfunction

   function automatic int unsigned pick_message_length();
      int unsigned pick;
      int near;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return $urandom_range(300, 700);
      end else if (pick < 6) begin
         near = int'(capacity_now) + int'($urandom_range(0, 4)) - 2;
         return (near < 0) ? 0 : ((near > 4095) ? 4095 : near);
      end else if (pick < 8) begin
         return $urandom_range(8, 4095);
      end
      return $urandom_range(8, 100);
   endfunction

   task automatic send_frame(logic [63:0] data, logic [3:0] len, logic last);
      int unsigned gap;
      gap = idle_cycles(req_steady);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_data <= data;
      req_chan.frame_len <= len;
      req_chan.last_frame <= last;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      frames_sent++;
      if (last) begin
         lists_sent++;
      end
   endtask

   task automatic send_noise(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_frame({$urandom, $urandom}, 4'($urandom_range(0, 15)), i == count - 1);
      end
   endtask

   // Frames of one message with random payload; fault_at corrupts one frame and stop_at
   // cuts the message short, each disabled by a negative index.
   task automatic send_message(int unsigned length, int fault_at, int stop_at,
                               bit close_list);
      logic [63:0] data;
      logic [3:0] len;
      logic [3:0] seq;
      int unsigned need;
      int unsigned sent;
      int unsigned take;
      int idx;
      bit final_frame;
      sent = 0;
      idx = 0;
      seq = 4'd1;
      final_frame = 1'b0;
      while (!final_frame) begin
         data = {$urandom, $urandom};
         if (idx == 0 && length <= 7) begin
            data[63:56] = {PCI_SINGLE, 4'(length)};
            need = length + 1;
            sent = length;
         end else if (idx == 0) begin
            data[63:48] = {PCI_FIRST, 12'(length)};
            need = 8;
            sent = 6;
         end else begin
            take = (length - sent > 7) ? 7 : length - sent;
            data[63:56] = {PCI_CONSECUTIVE, seq};
            need = take + 1;
            sent += take;
            seq = seq + 4'd1;
         end
         len = frame_len_for(need);
         if (idx == fault_at) begin
            case ($urandom_range(0, 3))
               0: data[59:56] = data[59:56] + 4'($urandom_range(1, 15));
               1: data[63:60] = data[63:60] ^ 4'($urandom_range(1, 15));
               2: len = 4'($urandom_range(0, need - 1));
               default: len = 4'd0;
            endcase
         end
         final_frame = (sent >= length) || (idx == stop_at);
         send_frame(data, len, final_frame && close_list);
         idx++;
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(logic [11:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_now = value;
      settings_used++;
   endtask

   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      forever begin
         stall = idle_cycles(rsp_steady);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [11:0] capacity_plan[PLAN_SIZE];
      int unsigned phase_end;
      int unsigned pick;
      int unsigned length;
      int unsigned frames;
      int fault_at;
      int stop_at;
      bit trailing;
      req_chan.valid <= 1'b0;
      req_chan.frame_data <= '0;
      req_chan.frame_len <= '0;
      req_chan.last_frame <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_frame(64'h00A5A5A5A5A5A5A5, 4'd1, 1'b1);
      send_frame(64'h07FFFFFFFFFFFFFF, 4'd8, 1'b1);
      send_frame(64'h0511223344556677, 4'd3, 1'b1);
      send_frame(64'h0811223344556677, 4'd8, 1'b1);
      send_frame(64'h0000000000000000, 4'd0, 1'b1);
      send_frame(64'h0701020304050607, 4'd15, 1'b1);
      send_frame(64'h3000000000000000, 4'd3, 1'b1);
      send_frame(64'h1007AABBCCDDEEFF, 4'd8, 1'b1);
      // Largest first frame, then a sequence error and frames ignored up to the list end.
      send_frame(64'h1FFF010203040506, 4'd8, 1'b0);
      send_frame(64'h2111121314151617, 4'd8, 1'b0);
      send_frame(64'h2321222324252627, 4'd8, 1'b0);
      send_frame(64'h2231323334353637, 4'd8, 1'b0);
      send_frame(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1);
      send_frame(64'h1008010203040506, 4'd7, 1'b1);
      send_frame(64'h100D010203040506, 4'd8, 1'b0);
      send_frame(64'h2107080910111213, 4'd8, 1'b1);
      send_frame(64'h1014010203040506, 4'd8, 1'b0);
      send_frame(64'h0107080910111213, 4'd8, 1'b0);
      send_frame({$urandom, $urandom}, 4'd4, 1'b1);
      send_frame(64'h1009010203040506, 4'd8, 1'b0);
      send_frame(64'h21070809A0B0C0D0, 4'd2, 1'b1);
      send_frame(64'h101E010203040506, 4'd8, 1'b0);
      send_frame(64'h2107080910111213, 4'd8, 1'b1);
      send_frame(64'h0000000000000000, 4'd8, 1'b1);
      send_frame(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1);

      capacity_plan = '{12'd0, 12'd7, 12'd8, 12'($urandom_range(9, 100)),
                        12'($urandom_range(101, 4094)), 12'd4095,
                        12'($urandom_range(0, 4095))};
      for (int unsigned p = 0; p < PLAN_SIZE; p++) begin
         set_capacity(capacity_plan[p]);
         phase_end = frames_sent + RANDOM_FRAMES / PLAN_SIZE;
         while (frames_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               req_steady = !req_steady;
            end
            if ($urandom_range(0, 9) == 0) begin
               rsp_steady = !rsp_steady;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               send_message($urandom_range(0, 7), ($urandom_range(0, 9) == 0) ? 0 : -1, -1,
                            1'b1);
            end else if (pick < 80) begin
               length = pick_message_length();
               frames = (length <= 7) ? 1 : 1 + (length - 6 + 6) / 7;
               fault_at = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, frames - 1))
                                                      : -1;
               if (length > 700) begin
                  stop_at = $urandom_range(0, 4);
               end else begin
                  stop_at = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, frames - 1))
                                                        : -1;
               end
               trailing = ($urandom_range(0, 4) == 0);
               send_message(length, fault_at, stop_at, !trailing);
               if (trailing) begin
                  send_noise($urandom_range(1, 3));
               end
            end else begin
               send_noise($urandom_range(1, 4));
            end
         end
      end

      settle();
      repeat (4) @(posedge clock);
      $display("Sent %0d frame transactions in %0d frame lists under %0d written capacity",
               frames_sent, lists_sent, settings_used);
      $display("settings, with directed length, type, sequence and truncation cases first.");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/isotp_pkg.sv
rtl/core/isotp_req_if.sv
rtl/core/isotp_rsp_if.sv
rtl/core/isotp_in_stage.sv
rtl/core/isotp_decode.sv
rtl/core/isotp_reassembler_top.sv
bench/isotp_reassembly_checker.sv
bench/tb.sv
